[sv/tka_pkg.sv]
package tka_pkg;

    // field widths
    localparam int LOGIT_W    = 16;
    localparam int TC_W       = 10;
    localparam int CC_W       = 11;
    localparam int TK_W       = 4;
    localparam int CNT_W      = 16;
    localparam int ACC_W      = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // default sizes
    localparam int DEF_MAX_K       = 10;
    localparam int DEF_MAX_CLASSES = 1024;

    // register reset values
    localparam logic [CC_W-1:0] CC_RESET = 11'd10;
    localparam logic [TK_W-1:0] TK_RESET = 4'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_K       = 1'b1;

    // saturation limit of the batch counts
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // divider: (hits << CNT_W) / rows, one quotient bit per step
    localparam int DIV_W     = 2 * CNT_W;
    localparam int DIV_STEPS = DIV_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic start;
        logic clear;
    } t_list_ctl;

    typedef struct packed {
        logic done;
        logic hit;
    } t_list_stat;

endpackage

[sv/tka_if.sv]
interface tka_in_if;
    import tka_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [LOGIT_W-1:0] logit;
    logic [TC_W-1:0]           label_class;
    logic                      last_in_batch;

    modport source (output valid, logit, label_class, last_in_batch, input ready);
    modport sink   (input valid, logit, label_class, last_in_batch, output ready);
endinterface

interface tka_out_if;
    import tka_pkg::*;

    logic              valid;
    logic              ready;
    logic              row_hit;
    logic [CNT_W-1:0]  correct_count;
    logic [CNT_W-1:0]  row_count;
    logic              batch_done;
    logic [ACC_W-1:0]  accuracy_q16;

    modport source (output valid, row_hit, correct_count, row_count, batch_done,
                    accuracy_q16, input ready);
    modport sink   (input valid, row_hit, correct_count, row_count, batch_done,
                    accuracy_q16, output ready);
endinterface

[sv/tka_list.sv]
module tka_list #(
    parameter int MAX_K       = tka_pkg::DEF_MAX_K,
    parameter int MAX_CLASSES = tka_pkg::DEF_MAX_CLASSES,
    localparam int CLS_W      = $clog2(MAX_CLASSES)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tka_pkg::t_list_ctl                i_ctl,
    output tka_pkg::t_list_stat               o_stat,
    input  logic signed [tka_pkg::LOGIT_W-1:0] i_logit,
    input  logic [CLS_W-1:0]                  i_cls,
    input  logic [CLS_W-1:0]                  i_label_class,
    input  logic [tka_pkg::TK_W-1:0]          i_top_k
);
    import tka_pkg::*;

    localparam int PTR_W = $clog2(MAX_K + 1);
    localparam int IX_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    logic signed [LOGIT_W-1:0] r_val  [MAX_K];
    logic [CLS_W-1:0]          r_cls  [MAX_K];
    logic [MAX_K-1:0]          r_fill;
    logic [PTR_W-1:0]          r_ptr;
    logic                      r_scan;
    logic                      r_done;

    logic                      ptr_end;
    logic [IX_W-1:0]           ix;
    logic                      advance;
    logic                      do_ins;
    logic                      hit;

    assign ptr_end = (r_ptr == PTR_W'(MAX_K));
    assign ix      = r_ptr[IX_W-1:0];
    // walk past entries that are filled and not beaten by the new logit
    assign advance = !ptr_end && r_fill[ix] && (i_logit <= r_val[ix]);
    assign do_ins  = r_scan && !ptr_end && !advance;

    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < MAX_K; i++) begin
            if (r_fill[i] && (r_cls[i] == i_label_class) && (i < int'(i_top_k))) begin
                hit = 1'b1;
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.hit  = hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ptr  <= '0;
            r_scan <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.clear) begin
                r_fill <= '0;
            end else if (do_ins) begin
                for (int i = 0; i < MAX_K; i++) begin
                    if (PTR_W'(i) > r_ptr) begin
                        r_fill[i] <= r_fill[i-1];
                    end else if (PTR_W'(i) == r_ptr) begin
                        r_fill[i] <= 1'b1;
                    end
                end
            end
            if (i_ctl.start) begin
                r_ptr  <= '0;
                r_scan <= 1'b1;
            end else if (r_scan) begin
                if (advance) begin
                    r_ptr <= r_ptr + PTR_W'(1);
                end else begin
                    r_scan <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // entry payload, shifted down one place below the insert point
    always_ff @(posedge i_clk) begin
        if (do_ins) begin
            for (int i = 0; i < MAX_K; i++) begin
                if (PTR_W'(i) > r_ptr) begin
                    r_val[i] <= r_val[i-1];
                    r_cls[i] <= r_cls[i-1];
                end else if (PTR_W'(i) == r_ptr) begin
                    r_val[i] <= i_logit;
                    r_cls[i] <= i_cls;
                end
            end
        end
    end

endmodule

[sv/tka_div.sv]
module tka_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tka_pkg::CNT_W-1:0]   i_num,
    input  logic [tka_pkg::CNT_W-1:0]   i_den,
    output logic                        o_done,
    output logic [tka_pkg::ACC_W-1:0]   o_quo
);
    import tka_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;

    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       diff;
    logic                 ge;

    // restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign ge    = (trial >= {1'b0, i_den});
    assign diff  = trial - {1'b0, i_den};

    assign o_done = r_done;
    assign o_quo  = r_quo[ACC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {i_num, {(DIV_W - CNT_W){1'b0}}};
        end else if (r_busy) begin
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

endmodule

[sv/top_k_accuracy_counter_unit.sv]
// channel  dir  handshake       word contents
// i_in     in   valid / ready   logit (s16 q8.8), label_class (10), last_in_batch (1)
// o_out    out  valid / ready   row_hit, correct_count, row_count, batch_done,
//                               accuracy_q16 (17)
// i_cfg    in   i_cfg_we        i_cfg_idx 0 = class_count, 1 = top_k, i_cfg_data
//
// a logit searches the sorted list one entry per cycle for the insert point,
// then is shifted in as the search ends; the row's last logit also passes
// through ST_RESULT, and on the batch's last row the 32-step restoring
// divider first computes hits * 65536 / rows
// i_in.ready is high only while idle; a finished word waits in the output
// register, and a new row end stalls until that register is free
// i_rst_n is synchronous, active low: empties the list, clears counts and position
module top_k_accuracy_counter_unit #(
    parameter int MAX_K       = tka_pkg::DEF_MAX_K,
    parameter int MAX_CLASSES = tka_pkg::DEF_MAX_CLASSES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tka_in_if.sink                           i_in,
    tka_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [tka_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tka_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tka_pkg::*;

    localparam int CLS_W = $clog2(MAX_CLASSES);
    // wide enough for the class count register and for MAX_CLASSES itself
    localparam int CMP_W = (CLS_W + 1 > CC_W) ? CLS_W + 1 : CC_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV_GO,
        ST_DIV,
        ST_RESULT
    } t_state;

    // configuration
    logic [CC_W-1:0]           r_class_count;
    logic [TK_W-1:0]           r_top_k;

    // sequencer and batch state
    t_state                    r_state;
    logic signed [LOGIT_W-1:0] r_logit;
    logic [TC_W-1:0]           r_tc;
    logic                      r_last;
    logic [CLS_W-1:0]          r_pos;
    logic [CNT_W-1:0]          r_hits;
    logic [CNT_W-1:0]          r_rows;
    logic                      r_hit;

    // output register
    logic                      r_ov;
    logic                      r_o_hit;
    logic [CNT_W-1:0]          r_o_corr;
    logic [CNT_W-1:0]          r_o_rows;
    logic                      r_o_done;
    logic [ACC_W-1:0]          r_o_acc;

    logic [CMP_W-1:0]          cc_ext;
    logic [CMP_W-1:0]          lim;
    logic [CMP_W-1:0]          eff_cnt;
    logic [CMP_W-1:0]          tc_ext;
    logic                      row_end;
    logic                      tc_ok;
    logic                      in_acc;
    logic                      out_free;
    logic                      row_hit;
    logic [CNT_W-1:0]          n_rows;
    logic [CNT_W-1:0]          n_hits;

    t_list_ctl                 list_ctl;
    t_list_stat                list_stat;
    logic                      div_start;
    logic                      div_done;
    logic [ACC_W-1:0]          div_quo;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count <= CC_RESET;
            r_top_k       <= TK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CLASS_COUNT: r_class_count <= i_cfg_data[CC_W-1:0];
                CFG_TOP_K:       r_top_k       <= i_cfg_data[TK_W-1:0];
            endcase
        end
    end

    // effective class count: zero acts as one, large values clamp
    always_comb begin
        cc_ext = CMP_W'(r_class_count);
        lim    = CMP_W'(MAX_CLASSES);
        if (cc_ext == '0) begin
            eff_cnt = CMP_W'(1);
        end else if (cc_ext > lim) begin
            eff_cnt = lim;
        end else begin
            eff_cnt = cc_ext;
        end
    end

    // row ends once position + 1 reaches the count, also after a lowered count
    assign row_end = (CMP_W'(r_pos) + CMP_W'(1)) >= eff_cnt;
    assign tc_ext  = CMP_W'(r_tc);
    assign tc_ok   = tc_ext < eff_cnt;
    assign row_hit = list_stat.hit && tc_ok;

    // rows saturate first; hits may still catch up to the saturated row count
    assign n_rows = (r_rows != CNT_MAX) ? r_rows + CNT_W'(1) : r_rows;
    assign n_hits = (row_hit && (r_hits != CNT_MAX)) ? r_hits + CNT_W'(1) : r_hits;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && (r_state == ST_IDLE);
    assign out_free   = !r_ov || o_out.ready;

    assign list_ctl.start = in_acc;
    assign list_ctl.clear = (r_state == ST_RESULT) && out_free;
    assign div_start      = (r_state == ST_DIV_GO);

    tka_list #(
        .MAX_K       (MAX_K),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_list (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (list_ctl),
        .o_stat        (list_stat),
        .i_logit       (r_logit),
        .i_cls         (r_pos),
        .i_label_class (tc_ext[CLS_W-1:0]),
        .i_top_k       (r_top_k)
    );

    tka_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_hits),
        .i_den   (r_rows),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_hits  <= '0;
            r_rows  <= '0;
            r_ov    <= 1'b0;
        end else begin
            // output register drains on acceptance unless a new word loads it
            if (r_ov && o_out.ready && !list_ctl.clear) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_logit <= i_in.logit;
                        r_tc    <= i_in.label_class;
                        r_last  <= i_in.last_in_batch;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (list_stat.done) begin
                        if (row_end) begin
                            r_hit  <= row_hit;
                            r_hits <= n_hits;
                            r_rows <= n_rows;
                            r_state <= r_last ? ST_DIV_GO : ST_RESULT;
                        end else begin
                            r_pos   <= r_pos + CLS_W'(1);
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_DIV_GO: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_o_hit  <= r_hit;
                        r_o_corr <= r_hits;
                        r_o_rows <= r_rows;
                        r_o_done <= r_last;
                        r_o_acc  <= r_last ? div_quo : '0;
                        r_pos    <= '0;
                        if (r_last) begin
                            r_hits <= '0;
                            r_rows <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.row_hit       = r_o_hit;
    assign o_out.correct_count = r_o_corr;
    assign o_out.row_count     = r_o_rows;
    assign o_out.batch_done    = r_o_done;
    assign o_out.accuracy_q16  = r_o_acc;

endmodule
